### design/mlp_pkg.sv
// shared constants, types and functions of the sigmoid network forward pass
// holds the logistic table built at elaboration; no dependencies
`timescale 1ns / 1ps

package mlp_pkg;

  localparam int LAYER_WIDTH           = 3;
  localparam int SIGMOID_TABLE_ENTRIES = 256;

  localparam int ACT_W  = 16;
  localparam int ROW_W  = ACT_W * LAYER_WIDTH;
  localparam int OPND_W = ACT_W + 1;
  localparam int PROD_W = ACT_W + OPND_W;
  localparam int ACC_W  = PROD_W + ((LAYER_WIDTH > 1) ? $clog2(LAYER_WIDTH) : 1);

  localparam int CFG_IDX_W = $clog2(2 * LAYER_WIDTH);

  // register index bases
  localparam int REG_HIDDEN_ROW_BASE = 0;
  localparam int REG_OUTPUT_ROW_BASE = LAYER_WIDTH;

  // fraction shifts of the two layers
  localparam int HIDDEN_SHIFT = 12;
  localparam int OUTPUT_SHIFT = 16;

  // pipeline latencies
  localparam int MAC_LAT = 2;
  localparam int SIG_LAT = 4;

  // logistic table
  localparam int ROM_DEPTH = SIGMOID_TABLE_ENTRIES + 1;
  localparam int IDX_W     = $clog2(ROM_DEPTH);
  localparam int P_W       = ACT_W + $clog2(SIGMOID_TABLE_ENTRIES);

  typedef logic signed [ACT_W-1:0]  q12_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic        [ACT_W-1:0]  q16_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic        [ROW_W-1:0]  row_t;

  typedef logic [ACT_W-1:0] rom_t [ROM_DEPTH];

  localparam acc_t SAT_MAX = acc_t'(32767);
  localparam acc_t SAT_MIN = -acc_t'(32768);

  // floor shift then saturate to signed q3.12
  function automatic q12_t sat_shift(acc_t a, int unsigned sh);
    acc_t s;
    s = a >>> sh;
    if (s > SAT_MAX) begin
      return q12_t'(SAT_MAX);
    end else if (s < SAT_MIN) begin
      return q12_t'(SAT_MIN);
    end
    return q12_t'(s);
  endfunction

  // shift and subtract division, elaboration only
  function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem  = rem - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [ACT_W-1:0] rom_point(int k);
    logic [63:0] q;
    logic [63:0] a;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] s;
    logic        neg;
    q   = (64'(k) << 28) / SIGMOID_TABLE_ENTRIES;
    neg = (q < (64'd1 << 27));
    a   = neg ? ((64'd1 << 27) - q) : (q - (64'd1 << 27));
    r   = a >> 4;
    term = 64'd1 << 24;
    e    = term;
    // taylor series of e^r in q24
    term = ((term * r) >> 24);          e = e + term;
    term = ((term * r) >> 24) / 64'd2;  e = e + term;
    term = ((term * r) >> 24) / 64'd3;  e = e + term;
    term = ((term * r) >> 24) / 64'd4;  e = e + term;
    term = ((term * r) >> 24) / 64'd5;  e = e + term;
    term = ((term * r) >> 24) / 64'd6;  e = e + term;
    term = ((term * r) >> 24) / 64'd7;  e = e + term;
    term = ((term * r) >> 24) / 64'd8;  e = e + term;
    term = ((term * r) >> 24) / 64'd9;  e = e + term;
    term = ((term * r) >> 24) / 64'd10; e = e + term;
    term = ((term * r) >> 24) / 64'd11; e = e + term;
    term = ((term * r) >> 24) / 64'd12; e = e + term;
    for (int n = 0; n < 4; n++) begin
      e = (e * e) >> 24;
    end
    e = e + (64'd1 << 24);
    s = udiv64((64'd1 << 40) + (e >> 1), e);
    if (neg) begin
      return s[ACT_W-1:0];
    end
    s = 64'd65536 - s;
    return (s > 64'd65535) ? 16'hFFFF : s[ACT_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      t[k] = rom_point(k);
    end
    return t;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

endpackage

### design/mlp_sigmoid_forward_pass.sv
// top level of the 3-3-3 sigmoid network forward pass
// depends on mlp_pkg, mlp_mac and mlp_sigmoid
`timescale 1ns / 1ps

// one input vector per cycle while in_stall is low, fully pipelined: a beat
// accepted at the input passes the hidden mac, hidden logistic, output mac
// and output logistic stages in turn. the whole pipe advances as one; it
// holds only while a finished result sits on the output and out_stall is
// high, and in_stall is exactly that condition. the six weight rows reset to
// zero; the user must write them via cfg only with the pipe empty (not checked).
module mlp_sigmoid_forward_pass (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [mlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlp_pkg::ROW_W-1:0]      cfg_wdata,
  // input vector
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [15:0]             in_input_activation_0,
  input  logic signed [15:0]             in_input_activation_1,
  input  logic signed [15:0]             in_input_activation_2,
  // result
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [15:0]                    out_hidden_activation_0,
  output logic [15:0]                    out_hidden_activation_1,
  output logic [15:0]                    out_hidden_activation_2,
  output logic [15:0]                    out_output_activation_0,
  output logic [15:0]                    out_output_activation_1,
  output logic [15:0]                    out_output_activation_2
);
  import mlp_pkg::*;

  localparam int HDLY = MAC_LAT + SIG_LAT;

  row_t   hid_w_r [LAYER_WIDTH];
  row_t   out_w_r [LAYER_WIDTH];

  logic   en;
  opnd_t  x_opnd   [LAYER_WIDTH];
  opnd_t  h_opnd   [LAYER_WIDTH];
  acc_t   hid_acc  [LAYER_WIDTH];
  acc_t   out_acc  [LAYER_WIDTH];
  q12_t   hid_pre  [LAYER_WIDTH];
  q12_t   out_pre  [LAYER_WIDTH];
  q16_t   hid_act  [LAYER_WIDTH];
  q16_t   out_act  [LAYER_WIDTH];
  logic   hid_acc_vld;
  logic   hid_act_vld;
  logic   out_acc_vld;
  logic   out_act_vld;

  // hidden values ride alongside the output layer
  q16_t   h_dly_r [HDLY][LAYER_WIDTH];

  // weight rows
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAYER_WIDTH; i++) begin
        hid_w_r[i] <= '0;
        out_w_r[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int i = 0; i < LAYER_WIDTH; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_HIDDEN_ROW_BASE + i)) begin
          hid_w_r[i] <= cfg_wdata;
        end
        if (cfg_index == CFG_IDX_W'(REG_OUTPUT_ROW_BASE + i)) begin
          out_w_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // the last logistic register is the output register
  assign en       = !out_act_vld || !out_stall;
  assign in_stall = !en;

  assign x_opnd[0] = OPND_W'(in_input_activation_0);
  assign x_opnd[1] = OPND_W'(in_input_activation_1);
  assign x_opnd[2] = OPND_W'(in_input_activation_2);

  mlp_mac u_hid_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .w_rows  (hid_w_r),
    .opnd    (x_opnd),
    .out_vld (hid_acc_vld),
    .acc     (hid_acc)
  );

  // q3.12 times q3.12, drop 12 fraction bits
  always_comb begin
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      hid_pre[i] = sat_shift(hid_acc[i], HIDDEN_SHIFT);
    end
  end

  mlp_sigmoid u_hid_sig (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (hid_acc_vld),
    .x       (hid_pre),
    .out_vld (hid_act_vld),
    .y       (hid_act)
  );

  // hidden values are unsigned q0.16
  always_comb begin
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      h_opnd[i] = {1'b0, hid_act[i]};
    end
  end

  mlp_mac u_out_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (hid_act_vld),
    .w_rows  (out_w_r),
    .opnd    (h_opnd),
    .out_vld (out_acc_vld),
    .acc     (out_acc)
  );

  // q3.12 times q0.16, drop 16 fraction bits
  always_comb begin
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      out_pre[i] = sat_shift(out_acc[i], OUTPUT_SHIFT);
    end
  end

  mlp_sigmoid u_out_sig (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (out_acc_vld),
    .x       (out_pre),
    .out_vld (out_act_vld),
    .y       (out_act)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      h_dly_r[0] <= hid_act;
      for (int s = 1; s < HDLY; s++) begin
        h_dly_r[s] <= h_dly_r[s-1];
      end
    end
  end

  assign out_valid               = out_act_vld;
  assign out_hidden_activation_0 = h_dly_r[HDLY-1][0];
  assign out_hidden_activation_1 = h_dly_r[HDLY-1][1];
  assign out_hidden_activation_2 = h_dly_r[HDLY-1][2];
  assign out_output_activation_0 = out_act[0];
  assign out_output_activation_1 = out_act[1];
  assign out_output_activation_2 = out_act[2];

endmodule

### design/mlp_mac.sv
// one layer of multiply-accumulate: products, then row sums
// depends on mlp_pkg
`timescale 1ns / 1ps

module mlp_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  mlp_pkg::row_t       w_rows [mlp_pkg::LAYER_WIDTH],
  input  mlp_pkg::opnd_t      opnd   [mlp_pkg::LAYER_WIDTH],
  output logic                out_vld,
  output mlp_pkg::acc_t       acc    [mlp_pkg::LAYER_WIDTH]
);
  import mlp_pkg::*;

  logic signed [PROD_W-1:0] prod_r [LAYER_WIDTH][LAYER_WIDTH];
  logic signed [PROD_W-1:0] prod_nxt [LAYER_WIDTH][LAYER_WIDTH];
  acc_t acc_r   [LAYER_WIDTH];
  acc_t acc_nxt [LAYER_WIDTH];
  logic vld1_r;
  logic vld2_r;

  always_comb begin
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      for (int j = 0; j < LAYER_WIDTH; j++) begin
        prod_nxt[i][j] = PROD_W'(signed'(w_rows[i][ACT_W*j +: ACT_W])) * PROD_W'(opnd[j]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      acc_nxt[i] = '0;
      for (int j = 0; j < LAYER_WIDTH; j++) begin
        acc_nxt[i] = acc_nxt[i] + ACC_W'(prod_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign acc     = acc_r;

endmodule

### design/mlp_sigmoid.sv
// logistic lookup with linear interpolation, four register stages
// depends on mlp_pkg (table and types)
`timescale 1ns / 1ps

module mlp_sigmoid (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  mlp_pkg::q12_t  x [mlp_pkg::LAYER_WIDTH],
  output logic           out_vld,
  output mlp_pkg::q16_t  y [mlp_pkg::LAYER_WIDTH]
);
  import mlp_pkg::*;

  q12_t              x_r  [LAYER_WIDTH];
  logic [ACT_W-1:0]  t0_r [LAYER_WIDTH];
  logic [ACT_W-1:0]  t1_r [LAYER_WIDTH];
  logic [ACT_W-1:0]  f_r  [LAYER_WIDTH];
  logic [32:0]       m0_r [LAYER_WIDTH];
  logic [31:0]       m1_r [LAYER_WIDTH];
  q16_t              y_r  [LAYER_WIDTH];

  logic [ACT_W-1:0]  t0_nxt [LAYER_WIDTH];
  logic [ACT_W-1:0]  t1_nxt [LAYER_WIDTH];
  logic [ACT_W-1:0]  f_nxt  [LAYER_WIDTH];
  q16_t              y_nxt  [LAYER_WIDTH];
  logic [SIG_LAT-1:0] vld_r;

  // table index and fraction from the offset argument
  always_comb begin
    logic [ACT_W-1:0] u;
    logic [P_W-1:0]   p;
    logic [IDX_W-1:0] idx;
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      u         = {~x_r[i][ACT_W-1], x_r[i][ACT_W-2:0]};
      p         = P_W'(u) * P_W'(SIGMOID_TABLE_ENTRIES);
      idx       = IDX_W'(p[P_W-1:ACT_W]);
      t0_nxt[i] = SIG_ROM[idx];
      t1_nxt[i] = SIG_ROM[idx + IDX_W'(1)];
      f_nxt[i]  = p[ACT_W-1:0];
    end
  end

  // rounded blend of the two points
  always_comb begin
    logic [33:0] sum;
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      sum      = 34'(m0_r[i]) + 34'(m1_r[i]) + 34'(32768);
      y_nxt[i] = sum[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SIG_LAT-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= x;
      t0_r <= t0_nxt;
      t1_r <= t1_nxt;
      f_r  <= f_nxt;
      for (int i = 0; i < LAYER_WIDTH; i++) begin
        m0_r[i] <= 33'(t0_r[i]) * (33'(17'h10000) - 33'(f_r[i]));
        m1_r[i] <= 32'(t1_r[i]) * 32'(f_r[i]);
      end
      y_r  <= y_nxt;
    end
  end

  assign out_vld = vld_r[SIG_LAT-1];
  assign y       = y_r;

endmodule

### design/mlp_checker.sv
// port level checks of the forward pass, bound to the top level
// depends on the handshake and result ports of mlp_sigmoid_forward_pass
`timescale 1ns / 1ps

module mlp_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [15:0]                    out_hidden_activation_0,
  input logic [15:0]                    out_hidden_activation_1,
  input logic [15:0]                    out_hidden_activation_2,
  input logic [15:0]                    out_output_activation_0,
  input logic [15:0]                    out_output_activation_1,
  input logic [15:0]                    out_output_activation_2
);

  // the pipe backs up only behind a waiting result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow a blocked output beat");

  // reset empties the pipe
  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_hidden_activation_0)
      && $stable(out_hidden_activation_1) && $stable(out_hidden_activation_2)
      && $stable(out_output_activation_0) && $stable(out_output_activation_1)
      && $stable(out_output_activation_2))
    else $error("stalled result beat changed");

endmodule

bind mlp_sigmoid_forward_pass mlp_checker u_mlp_checker (.*);

### tb/tb_mlp_sigmoid_forward_pass.sv
// self-checking bench for the 3-3-3 sigmoid network forward pass
// predicts each result beat with its own fixed-point network and logistic table, or uses a known value
// depends on mlp_pkg and the mlp_sigmoid_forward_pass design files
`timescale 1ns / 1ps

module tb_mlp_sigmoid_forward_pass;
  import mlp_pkg::*;

  // ---------------------------------------------------------------------------
  // types and named codes
  // ---------------------------------------------------------------------------
  // one input vector and one result beat, element 0 is the first field
  typedef logic [LAYER_WIDTH-1:0][ACT_W-1:0]   beat_vec_t;
  typedef logic [2*LAYER_WIDTH-1:0][ACT_W-1:0] act_set_t;

  // a directed step is either a weight write or an input beat
  typedef enum logic {STEP_WRITE, STEP_BEAT} step_kind_t;

  typedef struct {
    step_kind_t           kind;
    logic [CFG_IDX_W-1:0] index;
    row_t                 value;
    beat_vec_t            vec;
    bit                   known;
    act_set_t             want;
  } script_step_t;

  // weight codes in q3.12
  localparam q12_t W_MAX  = 16'sh7FFF;
  localparam q12_t W_MIN  = 16'sh8000;
  localparam q12_t W_ONE  = 16'sh1000;
  localparam q12_t W_NONE = 16'sh0000;

  // logistic of zero is exactly one half in q0.16
  localparam q16_t   HALF_SCALE   = 16'h8000;
  localparam act_set_t ALL_HALF   = {(2*LAYER_WIDTH){HALF_SCALE}};

  // the index port is wider than the register file; the top codes are unused
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_LO = CFG_IDX_W'(2 * LAYER_WIDTH);
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_HI = {CFG_IDX_W{1'b1}};

  // input to output delay through both layers
  localparam int PIPE_LAT = 2 * (MAC_LAT + SIG_LAT);

  localparam int RANDOM_PHASES    = 6;
  localparam int BEATS_PER_PHASE  = 75;

  // styles of random weight picks
  localparam int PICK_FULL    = 0;
  localparam int PICK_SMALL   = 1;
  localparam int PICK_EXTREME = 2;
  localparam int PICK_MID     = 3;

  // receiver stall styles
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;
  localparam int STALL_HALF  = 3;

  string field_name [2*LAYER_WIDTH] = '{
    "hidden_activation_0", "hidden_activation_1", "hidden_activation_2",
    "output_activation_0", "output_activation_1", "output_activation_2"
  };

  // ---------------------------------------------------------------------------
  // dut hookup, every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ROW_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  logic signed [15:0]   in_input_activation_0 = '0;
  logic signed [15:0]   in_input_activation_1 = '0;
  logic signed [15:0]   in_input_activation_2 = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [15:0]          out_hidden_activation_0;
  logic [15:0]          out_hidden_activation_1;
  logic [15:0]          out_hidden_activation_2;
  logic [15:0]          out_output_activation_0;
  logic [15:0]          out_output_activation_1;
  logic [15:0]          out_output_activation_2;

  mlp_sigmoid_forward_pass dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_wr_en               (cfg_wr_en),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_input_activation_0   (in_input_activation_0),
    .in_input_activation_1   (in_input_activation_1),
    .in_input_activation_2   (in_input_activation_2),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_hidden_activation_0 (out_hidden_activation_0),
    .out_hidden_activation_1 (out_hidden_activation_1),
    .out_hidden_activation_2 (out_hidden_activation_2),
    .out_output_activation_0 (out_output_activation_0),
    .out_output_activation_1 (out_output_activation_1),
    .out_output_activation_2 (out_output_activation_2)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: private copy of the weights and of the logistic table
  // ---------------------------------------------------------------------------
  row_t              weight_row [2*LAYER_WIDTH];
  longint unsigned   sig_table  [SIGMOID_TABLE_ENTRIES+1];
  act_set_t          pending_acts [$];
  int                mismatches = 0;

  // table point k sits at x = -8 + 16k/entries; e^|x| from a truncated series
  // of e^(|x|/16), squared four times, then 1/(1+e^|x|) in q0.16, taken from one for x >= 0
  function automatic longint unsigned table_point(int k);
    longint          xq;
    longint unsigned mag;
    longint unsigned r;
    longint unsigned term;
    longint unsigned e;
    longint unsigned s;
    xq   = longint'((longint'(k) << 28) / SIGMOID_TABLE_ENTRIES) - (longint'(1) << 27);
    mag  = (xq < 0) ? longint'(-xq) : longint'(xq);
    r    = mag >> 4;
    term = 64'd1 << 24;
    e    = term;
    for (longint unsigned n = 1; n <= 12; n++) begin
      term = ((term * r) >> 24) / n;
      e    = e + term;
    end
    for (int n = 0; n < 4; n++) begin
      e = (e * e) >> 24;
    end
    e = e + (64'd1 << 24);
    s = ((64'd1 << 40) + (e >> 1)) / e;
    if (xq < 0) begin
      return s;
    end
    s = 64'd65536 - s;
    return (s > 64'd65535) ? 64'd65535 : s;
  endfunction

  // floor shift then clamp to the q3.12 range
  function automatic longint clamp_q12(longint acc, int sh);
    longint s;
    s = acc >>> sh;
    if (s > 32767) begin
      return 32767;
    end else if (s < -32768) begin
      return -32768;
    end
    return s;
  endfunction

  // table lookup with linear interpolation between neighbors
  function automatic q16_t squash(longint x);
    longint unsigned u;
    longint unsigned p;
    longint unsigned seg;
    longint unsigned frac;
    u    = longint'(x + 32768);
    p    = u * SIGMOID_TABLE_ENTRIES;
    seg  = p >> 16;
    frac = p & 64'hFFFF;
    if (seg >= SIGMOID_TABLE_ENTRIES) begin
      seg = SIGMOID_TABLE_ENTRIES - 1;
    end
    return q16_t'((sig_table[seg] * (64'd65536 - frac) + sig_table[seg+1] * frac
                   + 64'd32768) >> 16);
  endfunction

  // both layers for one input vector
  function automatic act_set_t forward_pass(beat_vec_t xin);
    act_set_t res;
    longint   acc;
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      acc = 0;
      for (int j = 0; j < LAYER_WIDTH; j++) begin
        acc += longint'(q12_t'(weight_row[REG_HIDDEN_ROW_BASE+i][ACT_W*j +: ACT_W]))
             * longint'(q12_t'(xin[j]));
      end
      res[i] = squash(clamp_q12(acc, HIDDEN_SHIFT));
    end
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      acc = 0;
      for (int j = 0; j < LAYER_WIDTH; j++) begin
        acc += longint'(q12_t'(weight_row[REG_OUTPUT_ROW_BASE+i][ACT_W*j +: ACT_W]))
             * longint'(res[j]);
      end
      res[LAYER_WIDTH+i] = squash(clamp_q12(acc, OUTPUT_SHIFT));
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic row_t pack_row(q12_t w0, q12_t w1, q12_t w2);
    return {w2, w1, w0};
  endfunction

  function automatic script_step_t write_step(logic [CFG_IDX_W-1:0] idx, row_t val);
    script_step_t st;
    st       = '{kind: STEP_WRITE, default: '0};
    st.kind  = STEP_WRITE;
    st.index = idx;
    st.value = val;
    return st;
  endfunction

  function automatic script_step_t beat_step(q12_t x0, q12_t x1, q12_t x2, bit known);
    script_step_t st;
    st       = '{kind: STEP_BEAT, default: '0};
    st.kind  = STEP_BEAT;
    st.vec   = {x2, x1, x0};
    st.known = known;
    st.want  = ALL_HALF;
    return st;
  endfunction

  function automatic q12_t pick_weight(int style);
    case (style)
      PICK_FULL:    return q12_t'($urandom);
      PICK_SMALL:   return q12_t'(int'($urandom_range(0, 'h3000)) - 'h1800);
      PICK_EXTREME: begin
        case ($urandom_range(0, 2))
          0:       return W_MAX;
          1:       return W_MIN;
          default: return W_NONE;
        endcase
      end
      default:      return q12_t'(int'($urandom_range(0, 'h8000)) - 'h4000);
    endcase
  endfunction

  // mostly full-range activations, some near zero, a few at the rails
  function automatic q12_t pick_activation();
    case ($urandom_range(0, 7))
      0:       return pick_weight(PICK_EXTREME);
      1, 2:    return pick_weight(PICK_SMALL);
      default: return q12_t'($urandom);
    endcase
  endfunction

  // weight write; the caller lowers cfg_wr_en after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, row_t val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx < 2 * LAYER_WIDTH) begin
      weight_row[idx] = val;
    end
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_acts.size() != 0) @(posedge clk);
  endtask

  // sender bursts: random burst length, random gap, sometimes no gap at all
  int burst_left = 0;

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one beat and hold it until taken; records the expected result
  task automatic send_beat(beat_vec_t vec, bit known, act_set_t want);
    in_valid              <= 1'b1;
    in_input_activation_0 <= vec[0];
    in_input_activation_1 <= vec[1];
    in_input_activation_2 <= vec[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_acts.push_back(known ? want : forward_pass(vec));
  endtask

  // ---------------------------------------------------------------------------
  // receiver: changing stall styles plus long hold-offs that back up the pipe
  // ---------------------------------------------------------------------------
  int taken_beats      = 0;
  int next_hold_at     = 200;
  int hold_left        = 0;
  int stall_style      = STALL_NONE;
  int stall_phase_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        taken_beats++;
      end
      // long hold-off: the sender keeps offering so in_stall must rise
      if (hold_left == 0 && taken_beats >= next_hold_at) begin
        hold_left    = 120;
        next_hold_at = next_hold_at + 180;
      end
      if (stall_phase_left == 0) begin
        stall_style      = $urandom_range(STALL_NONE, STALL_HALF);
        stall_phase_left = $urandom_range(8, 80);
      end else begin
        stall_phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:     out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checker: every taken beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    act_set_t got;
    act_set_t exp_acts;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_output_activation_2, out_output_activation_1, out_output_activation_0,
             out_hidden_activation_2, out_hidden_activation_1, out_hidden_activation_0};
      if (pending_acts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result beat with nothing pending: %h", $realtime, got);
        end
      end else begin
        exp_acts = pending_acts.pop_front();
        for (int f = 0; f < 2 * LAYER_WIDTH; f++) begin
          if (got[f] !== exp_acts[f]) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: %s expected %h, got %h", $realtime, field_name[f],
                       exp_acts[f], got[f]);
            end
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  script_step_t script [$];

  initial begin
    for (int k = 0; k <= SIGMOID_TABLE_ENTRIES; k++) begin
      sig_table[k] = table_point(k);
    end
    for (int i = 0; i < 2 * LAYER_WIDTH; i++) begin
      weight_row[i] = '0;
    end

    // zero weights after reset: every activation is the midpoint
    script.push_back(beat_step(W_NONE, W_NONE, W_NONE, 1'b1));
    script.push_back(beat_step(W_MAX, W_MIN, 16'sh0001, 1'b1));
    script.push_back(beat_step(W_MIN, W_MAX, 16'shFFFF, 1'b1));
    // writes to unused indexes must not reach any row
    script.push_back(write_step(SPARE_INDEX_LO, {ROW_W{1'b1}}));
    script.push_back(write_step(SPARE_INDEX_HI, {ROW_W{1'b1}}));
    script.push_back(beat_step(W_MAX, W_MAX, W_MAX, 1'b1));
    // rail weights: hidden 0 row at the top rail, hidden 1 at the bottom, hidden 2 passes x0
    script.push_back(write_step(CFG_IDX_W'(REG_HIDDEN_ROW_BASE + 0),
                                pack_row(W_MAX, W_MAX, W_MAX)));
    script.push_back(write_step(CFG_IDX_W'(REG_HIDDEN_ROW_BASE + 1),
                                pack_row(W_MIN, W_MIN, W_MIN)));
    script.push_back(write_step(CFG_IDX_W'(REG_HIDDEN_ROW_BASE + 2),
                                pack_row(W_ONE, W_NONE, W_NONE)));
    script.push_back(write_step(CFG_IDX_W'(REG_OUTPUT_ROW_BASE + 0),
                                pack_row(W_MAX, W_MAX, W_MAX)));
    script.push_back(write_step(CFG_IDX_W'(REG_OUTPUT_ROW_BASE + 1),
                                pack_row(W_MIN, W_MIN, W_MIN)));
    script.push_back(write_step(CFG_IDX_W'(REG_OUTPUT_ROW_BASE + 2),
                                pack_row(W_ONE, 16'shF000, W_NONE)));
    script.push_back(beat_step(W_MAX, W_MAX, W_MAX, 1'b0));
    script.push_back(beat_step(W_MIN, W_MIN, W_MIN, 1'b0));
    script.push_back(beat_step(W_NONE, W_NONE, W_NONE, 1'b0));
    script.push_back(beat_step(16'sh0001, 16'shFFFF, W_NONE, 1'b0));
    script.push_back(beat_step(W_ONE, W_ONE, W_ONE, 1'b0));
    script.push_back(beat_step(16'shF000, 16'sh0800, W_NONE, 1'b0));
    script.push_back(beat_step(W_MAX, W_MIN, W_MAX, 1'b0));
    script.push_back(beat_step(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0));
    // x0 alone drives hidden 2 to both ends of the logistic table
    script.push_back(beat_step(W_MIN, W_NONE, W_NONE, 1'b0));
    script.push_back(beat_step(W_MAX, W_NONE, W_NONE, 1'b0));
    // hidden all at one half, output sums 0 and 1 saturate
    for (int i = 0; i < LAYER_WIDTH; i++) begin
      script.push_back(write_step(CFG_IDX_W'(REG_HIDDEN_ROW_BASE + i), '0));
    end
    script.push_back(beat_step(16'sh1234, -16'sh1234, W_NONE, 1'b0));
    script.push_back(beat_step(W_MIN, W_MAX, W_ONE, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed part; weight writes only with the pipe empty
    foreach (script[n]) begin
      if (script[n].kind == STEP_WRITE) begin
        in_valid <= 1'b0;
        wait_drained();
        write_reg(script[n].index, script[n].value);
      end else begin
        cfg_wr_en <= 1'b0;
        pace();
        send_beat(script[n].vec, script[n].known, script[n].want);
      end
    end

    // random phases, each with a fresh set of weights
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drained();
      for (int r = 0; r < 2 * LAYER_WIDTH; r++) begin
        q12_t w [LAYER_WIDTH];
        for (int j = 0; j < LAYER_WIDTH; j++) begin
          case (ph)
            0:       w[j] = W_MAX;
            1:       w[j] = W_MIN;
            default: w[j] = pick_weight($urandom_range(PICK_FULL, PICK_MID));
          endcase
        end
        write_reg(CFG_IDX_W'(r), pack_row(w[0], w[1], w[2]));
      end
      cfg_wr_en <= 1'b0;
      for (int b = 0; b < BEATS_PER_PHASE; b++) begin
        // once, the sender stops until everything has come back
        if (ph == 3 && b == BEATS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        pace();
        send_beat({pick_activation(), pick_activation(), pick_activation()},
                  1'b0, ALL_HALF);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // safety net well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
